FILE: src/cdad_pkg.sv
// shared types, constants and calendar helpers for the date adder
package cdad_pkg;

	// field widths
	localparam int YEAR_W   = 14;
	localparam int MONTH_W  = 4;
	localparam int DAY_W    = 5;
	localparam int WEEKS_W  = 12;
	localparam int ADD_W    = 16;

	// running day count: 31 + 65535 + 7 * 4095 stays below 2^17
	localparam int SUM_W    = 17;

	// year kept as position inside its century plus century count
	localparam int CENT_W   = 8;
	localparam int R100_W   = 7;

	// reciprocal of 100 for the century split, exact for years below 2^14
	localparam int RECIP_W     = 13;
	localparam int RECIP_SHIFT = 19;
	localparam int PROD_W      = YEAR_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP_100 = RECIP_W'(5243);

	localparam logic [YEAR_W-1:0]  YEAR_MIN  = YEAR_W'(1);
	localparam logic [YEAR_W-1:0]  YEAR_MAX  = YEAR_W'(16383);
	localparam logic [YEAR_W-1:0]  CENTURY   = YEAR_W'(100);
	localparam logic [R100_W-1:0]  LAST_YEAR_IN_CENT = R100_W'(99);
	localparam logic [MONTH_W-1:0] MONTH_JAN = MONTH_W'(1);
	localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
	localparam logic [MONTH_W-1:0] MONTH_APR = MONTH_W'(4);
	localparam logic [MONTH_W-1:0] MONTH_JUN = MONTH_W'(6);
	localparam logic [MONTH_W-1:0] MONTH_SEP = MONTH_W'(9);
	localparam logic [MONTH_W-1:0] MONTH_NOV = MONTH_W'(11);
	localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);
	localparam logic [DAY_W-1:0]   DAY_FIRST = DAY_W'(1);
	localparam logic [DAY_W-1:0]   DAY_LAST  = DAY_W'(31);

	// defaults for the top-level parameters
	localparam int DEF_DAY_OFFSET_BITS = 16;
	localparam int DEF_QUEUE_DEPTH     = 2;

	// one classified date waiting for the month stepper
	typedef struct packed {
		logic [YEAR_W-1:0]  year;
		logic [MONTH_W-1:0] month;
		logic [SUM_W-1:0]   day;
		logic [R100_W-1:0]  yr_in_cent;
		logic [1:0]         cent_mod4;
	} job_t;

	typedef enum logic {
		BK_IDLE,
		BK_RUN
	} bk_state_t;

	// gregorian leap rule from the split year
	function automatic logic is_leap(input logic [1:0] year_lo, input logic [R100_W-1:0] r100,
		input logic [1:0] cent_mod4);
		logic leap;
		if (r100 == '0) begin
			leap = (cent_mod4 == 2'd0);
		end else begin
			leap = (year_lo == 2'd0);
		end
		return leap;
	endfunction

	// days in a month
	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m, input logic leap);
		logic [DAY_W-1:0] len;
		case (m) inside
			MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = DAY_W'(30);
			MONTH_FEB: len = leap ? DAY_W'(29) : DAY_W'(28);
			default:   len = DAY_W'(31);
		endcase
		return len;
	endfunction

endpackage

FILE: src/cdad_front.sv
// front end: clamps the start date, forms the day offset and splits the year by century
module cdad_front import cdad_pkg::*; #(
	parameter int DAY_OFFSET_BITS = DEF_DAY_OFFSET_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [YEAR_W-1:0]  start_year,
	input  logic [MONTH_W-1:0] start_month,
	input  logic [DAY_W-1:0]   start_day,
	input  logic [WEEKS_W-1:0] add_weeks,
	input  logic [ADD_W-1:0]   add_days,
	output logic               push_valid,
	input  logic               push_ready,
	output job_t               push_data
);

	localparam int EFF_BITS = (DAY_OFFSET_BITS > ADD_W) ? ADD_W : DAY_OFFSET_BITS;
	localparam logic [ADD_W-1:0] ADD_MASK = ADD_W'((64'd1 << EFF_BITS) - 64'd1);

	logic [YEAR_W-1:0]  year_c;
	logic [MONTH_W-1:0] month_c;
	logic [DAY_W-1:0]   day_c;
	logic [SUM_W-1:0]   sum_c;
	logic [PROD_W-1:0]  prod_c;

	logic               valid_s1;
	logic [YEAR_W-1:0]  year_s1;
	logic [MONTH_W-1:0] month_s1;
	logic [SUM_W-1:0]   day_s1;
	logic [CENT_W-1:0]  cent_s1;
	logic [YEAR_W-1:0]  cent_years;
	logic [YEAR_W-1:0]  r100_wide;

	// clamp out-of-range start fields
	always_comb begin
		year_c  = (start_year == '0) ? YEAR_MIN : start_year;
		month_c = start_month;
		if (start_month == '0) begin
			month_c = MONTH_JAN;
		end else if (start_month > MONTH_DEC) begin
			month_c = MONTH_DEC;
		end
		day_c = (start_day == '0) ? DAY_FIRST : start_day;
	end

	// day + days + 7 * weeks, seven times as eight minus one
	assign sum_c = SUM_W'(day_c) + SUM_W'(add_days & ADD_MASK)
		+ (SUM_W'(add_weeks) << 3) - SUM_W'(add_weeks);

	// year / 100 by reciprocal
	assign prod_c = PROD_W'(year_c) * PROD_W'(RECIP_100);

	assign in_ready = !valid_s1 || push_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			year_s1  <= year_c;
			month_s1 <= month_c;
			day_s1   <= sum_c;
			cent_s1  <= prod_c[RECIP_SHIFT +: CENT_W];
		end
	end

	// remainder within the century
	assign cent_years = YEAR_W'(cent_s1) * CENTURY;
	assign r100_wide  = year_s1 - cent_years;

	assign push_valid = valid_s1;
	always_comb begin
		push_data.year       = year_s1;
		push_data.month      = month_s1;
		push_data.day        = day_s1;
		push_data.yr_in_cent = r100_wide[R100_W-1:0];
		push_data.cent_mod4  = cent_s1[1:0];
	end

endmodule

FILE: src/cdad_queue.sv
// small fifo between the front end and the month stepper
module cdad_queue import cdad_pkg::*; #(
	parameter int DEPTH = DEF_QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_valid,
	output logic wr_ready,
	input  job_t wr_data,
	output logic rd_valid,
	input  logic rd_ready,
	output job_t rd_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	job_t             entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign wr_ready = (cnt_q != CNT_FULL);
	assign rd_valid = (cnt_q != '0);
	assign rd_data  = entry_q[rd_ptr_q];
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_valid && rd_ready;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

`ifndef NO_ASSERTIONS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_FULL)
		else $error("queue fill count beyond depth");
`endif

endmodule

FILE: src/cdad_back.sv
// back end: steps one month per cycle until the day fits, then registers the result
module cdad_back import cdad_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               job_valid,
	output logic               job_ready,
	input  job_t               job_data,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [YEAR_W-1:0]  end_year,
	output logic [MONTH_W-1:0] end_month,
	output logic [DAY_W-1:0]   end_day
);

	bk_state_t          state_q;
	bk_state_t          state_d;
	logic [YEAR_W-1:0]  year_q;
	logic [MONTH_W-1:0] month_q;
	logic [SUM_W-1:0]   day_q;
	logic [R100_W-1:0]  r100_q;
	logic [1:0]         cmod4_q;
	logic               out_valid_q;
	logic [YEAR_W-1:0]  end_year_q;
	logic [MONTH_W-1:0] end_month_q;
	logic [DAY_W-1:0]   end_day_q;

	logic               leap;
	logic [DAY_W-1:0]   len;
	logic               over;
	logic               load;
	logic               finish;

	// current month length and loop test
	assign leap = is_leap(year_q[1:0], r100_q, cmod4_q);
	assign len  = month_len(month_q, leap);
	assign over = (day_q > SUM_W'(len));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and handshake
	always_comb begin
		state_d   = state_q;
		job_ready = 1'b0;
		load      = 1'b0;
		finish    = 1'b0;
		case (state_q)
			BK_IDLE: begin
				job_ready = 1'b1;
				if (job_valid) begin
					load    = 1'b1;
					state_d = BK_RUN;
				end
			end
			BK_RUN: begin
				if (!over && (!out_valid_q || out_ready)) begin
					finish  = 1'b1;
					state_d = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	// month stepper, saturating past the last year
	always_ff @(posedge clk) begin
		if (load) begin
			year_q  <= job_data.year;
			month_q <= job_data.month;
			day_q   <= job_data.day;
			r100_q  <= job_data.yr_in_cent;
			cmod4_q <= job_data.cent_mod4;
		end else if (state_q == BK_RUN && over) begin
			if (month_q == MONTH_DEC && year_q == YEAR_MAX) begin
				day_q <= SUM_W'(DAY_LAST);
			end else begin
				day_q <= day_q - SUM_W'(len);
			end
			if (month_q == MONTH_DEC) begin
				if (year_q == YEAR_MAX) begin
					month_q <= MONTH_DEC;
				end else begin
					month_q <= MONTH_JAN;
					year_q  <= year_q + YEAR_W'(1);
					if (r100_q == LAST_YEAR_IN_CENT) begin
						r100_q  <= '0;
						cmod4_q <= cmod4_q + 2'd1;
					end else begin
						r100_q <= r100_q + R100_W'(1);
					end
				end
			end else begin
				month_q <= month_q + MONTH_W'(1);
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			end_year_q  <= year_q;
			end_month_q <= month_q;
			end_day_q   <= day_q[DAY_W-1:0];
		end
	end

	assign out_valid = out_valid_q;
	assign end_year  = end_year_q;
	assign end_month = end_month_q;
	assign end_day   = end_day_q;

`ifndef NO_ASSERTIONS
	a_out_month: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (end_month_q >= MONTH_JAN && end_month_q <= MONTH_DEC))
		else $error("result month out of range");
	a_out_day: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (end_day_q != '0))
		else $error("result day is zero");
	a_run_day: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_RUN && over) |=> (day_q != '0))
		else $error("month step left day at zero");
`endif

endmodule

FILE: src/calendar_date_add_days.sv
// path: the front-end register, the queue, the stepper load, one step per month crossed, then the output register
// the month stepper handles one date at a time and takes a new one only once the last is done;
// the front end keeps accepting until the queue fills
// reset: arst_n clears all valid flags, the queue and the stepper state asynchronously
// top level of the gregorian date adder
module calendar_date_add_days import cdad_pkg::*; #(
	parameter int DAY_OFFSET_BITS = DEF_DAY_OFFSET_BITS,
	parameter int QUEUE_DEPTH     = DEF_QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [YEAR_W-1:0]  start_year,
	input  logic [MONTH_W-1:0] start_month,
	input  logic [DAY_W-1:0]   start_day,
	input  logic [WEEKS_W-1:0] add_weeks,
	input  logic [ADD_W-1:0]   add_days,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [YEAR_W-1:0]  end_year,
	output logic [MONTH_W-1:0] end_month,
	output logic [DAY_W-1:0]   end_day
);

	logic push_valid;
	logic push_ready;
	job_t push_data;
	logic job_valid;
	logic job_ready;
	job_t job_data;

	// classify the transfer
	cdad_front #(
		.DAY_OFFSET_BITS(DAY_OFFSET_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.start_year (start_year),
		.start_month(start_month),
		.start_day  (start_day),
		.add_weeks  (add_weeks),
		.add_days   (add_days),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	// decouple front and back
	cdad_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_valid(push_valid),
		.wr_ready(push_ready),
		.wr_data (push_data),
		.rd_valid(job_valid),
		.rd_ready(job_ready),
		.rd_data (job_data)
	);

	// walk the months
	cdad_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.job_valid(job_valid),
		.job_ready(job_ready),
		.job_data (job_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.end_year (end_year),
		.end_month(end_month),
		.end_day  (end_day)
	);

endmodule

FILE: tb/calendar_date_add_days_tb.sv
// self-checking testbench for the gregorian date adder with a date scoreboard
module calendar_date_add_days_tb;
	import cdad_pkg::*;

	localparam int OFFSET_BITS = 16;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int SETTLE_CYCLES = 16;
	localparam int REPORT_LIMIT = 10;
	localparam int RANDOM_DATES = 120;
	localparam int CALM_FROM = 90;

	typedef struct packed {
		logic [YEAR_W-1:0]  year;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
	} cal_date_t;

	// expected end dates in transfer order, plus the calendar arithmetic that produces them
	class date_ledger;
		cal_date_t pending[$];
		int errors;
		int mismatches;

		function new();
			errors = 0;
			mismatches = 0;
		endfunction

		function int unsigned days_in_month(int unsigned mon, int unsigned yr);
			bit leap;
			leap = (yr % 400 == 0) || ((yr % 100 != 0) && (yr % 4 == 0));
			case (mon)
				4, 6, 9, 11: return 30;
				2: return leap ? 29 : 28;
				default: return 31;
			endcase
		endfunction

		// walk forward one month at a time until the day fits
		function cal_date_t shift_date(logic [YEAR_W-1:0] y_in, logic [MONTH_W-1:0] m_in,
			logic [DAY_W-1:0] d_in, logic [WEEKS_W-1:0] w_in, logic [ADD_W-1:0] a_in);
			int unsigned yr, mon, dy, extra, span;
			cal_date_t res;
			yr = y_in;
			mon = m_in;
			dy = d_in;
			extra = a_in;
			extra = extra & ((32'd1 << OFFSET_BITS) - 1);
			if (yr == 0) yr = YEAR_MIN;
			if (mon == 0) mon = MONTH_JAN;
			if (mon > MONTH_DEC) mon = MONTH_DEC;
			if (dy == 0) dy = DAY_FIRST;
			dy = dy + extra + 7 * w_in;
			span = days_in_month(mon, yr);
			while (dy > span) begin
				dy -= span;
				mon++;
				if (mon > MONTH_DEC) begin
					mon = MONTH_JAN;
					yr++;
					// past the last representable year the result pins to its final day
					if (yr > YEAR_MAX) begin
						yr = YEAR_MAX;
						mon = MONTH_DEC;
						dy = DAY_LAST;
						break;
					end
				end
				span = days_in_month(mon, yr);
			end
			res.year = YEAR_W'(yr);
			res.month = MONTH_W'(mon);
			res.day = DAY_W'(dy);
			return res;
		endfunction

		function void note_input(logic [YEAR_W-1:0] y_in, logic [MONTH_W-1:0] m_in,
			logic [DAY_W-1:0] d_in, logic [WEEKS_W-1:0] w_in, logic [ADD_W-1:0] a_in);
			pending.push_back(shift_date(y_in, m_in, d_in, w_in, a_in));
		endfunction

		function void check_result(cal_date_t got);
			cal_date_t want;
			if (pending.size() == 0) begin
				errors++;
				if (mismatches < REPORT_LIMIT)
					$display("unexpected result %0d-%0d-%0d", got.year, got.month, got.day);
				mismatches++;
				return;
			end
			want = pending.pop_front();
			if (got.year !== want.year || got.month !== want.month || got.day !== want.day) begin
				errors++;
				if (mismatches < REPORT_LIMIT)
					$display("date mismatch: expected %0d-%0d-%0d, got %0d-%0d-%0d",
						want.year, want.month, want.day, got.year, got.month, got.day);
				mismatches++;
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [YEAR_W-1:0]  start_year;
	logic [MONTH_W-1:0] start_month;
	logic [DAY_W-1:0]   start_day;
	logic [WEEKS_W-1:0] add_weeks;
	logic [ADD_W-1:0]   add_days;
	logic               out_valid;
	logic               out_ready;
	logic [YEAR_W-1:0]  end_year;
	logic [MONTH_W-1:0] end_month;
	logic [DAY_W-1:0]   end_day;

	date_ledger ledger = new();
	bit sender_idles;
	bit sink_stalls;
	int cycle_count;

	calendar_date_add_days #(
		.DAY_OFFSET_BITS(OFFSET_BITS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.start_year(start_year),
		.start_month(start_month),
		.start_day(start_day),
		.add_weeks(add_weeks),
		.add_days(add_days),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.end_year(end_year),
		.end_month(end_month),
		.end_day(end_day)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// watchdog
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// result side: random stall bursts while enabled
	initial begin
		int stall_left;
		stall_left = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!sink_stalls) begin
				stall_left = 0;
			end else if (stall_left == 0 && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 8);
			end
			out_ready = (stall_left == 0);
			if (stall_left > 0) stall_left--;
		end
	end

	// check every result transfer
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			ledger.check_result('{end_year, end_month, end_day});
	end

	// present one start date, holding it until the transfer, with an optional gap first
	task automatic send_date(logic [YEAR_W-1:0] yr, logic [MONTH_W-1:0] mon,
		logic [DAY_W-1:0] dy, logic [WEEKS_W-1:0] wk, logic [ADD_W-1:0] extra);
		if (sender_idles && $urandom_range(0, 3) == 0) begin
			@(negedge clk);
			in_valid = 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end else begin
			@(negedge clk);
		end
		start_year = yr;
		start_month = mon;
		start_day = dy;
		add_weeks = wk;
		add_days = extra;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		ledger.note_input(yr, mon, dy, wk, extra);
	endtask

	task automatic wait_for_dates();
		@(negedge clk);
		in_valid = 1'b0;
		while (ledger.pending.size() != 0) @(posedge clk);
	endtask

	// random start dates, mostly short offsets, with leap years, the top of the year range
	// and a handful of long offsets mixed in
	task automatic send_random_date();
		int pick;
		logic [YEAR_W-1:0]  yr;
		logic [MONTH_W-1:0] mon;
		logic [DAY_W-1:0]   dy;
		logic [WEEKS_W-1:0] wk;
		logic [ADD_W-1:0]   extra;
		pick = $urandom_range(0, 99);
		yr = $urandom_range(0, 16383);
		mon = $urandom_range(0, 15);
		dy = $urandom_range(0, 31);
		if (pick < 60) begin
			wk = $urandom_range(0, 8);
			extra = $urandom_range(0, 400);
		end else if (pick < 80) begin
			case ($urandom_range(0, 5))
				0: yr = 1600;
				1: yr = 1900;
				2: yr = 2000;
				3: yr = 2100;
				4: yr = $urandom_range(1, 2499) * 4;
				default: yr = YEAR_MAX;
			endcase
			mon = $urandom_range(1, 3);
			dy = $urandom_range(27, 31);
			wk = $urandom_range(0, 1);
			extra = $urandom_range(0, 70);
		end else if (pick < 90) begin
			yr = $urandom_range(16300, 16383);
			mon = $urandom_range(9, 12);
			wk = $urandom_range(0, 60);
			extra = $urandom_range(0, 3000);
		end else if (pick < 96) begin
			wk = $urandom_range(0, 511);
			extra = $urandom_range(0, 8191);
		end else begin
			wk = $urandom_range(0, 4095);
			extra = $urandom_range(0, 65535);
		end
		send_date(yr, mon, dy, wk, extra);
	endtask

	// main sequence
	initial begin
		int i;
		arst_n = 1'b0;
		in_valid = 1'b0;
		start_year = '0;
		start_month = '0;
		start_day = '0;
		add_weeks = '0;
		add_days = '0;
		sender_idles = 1'b1;
		sink_stalls = 1'b1;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed dates
		send_date(2024, 1, 1, 0, 0);
		// zero year, month and day all clamp up
		send_date(0, 0, 0, 0, 0);
		// month above december clamps to december
		send_date(2023, 15, 31, 0, 1);
		send_date(2023, 13, 1, 0, 0);
		// day past the end of february rolls into march
		send_date(2023, 2, 31, 0, 0);
		// leap rule: every fourth year, not centuries, but every fourth century
		send_date(2000, 2, 28, 0, 1);
		send_date(1900, 2, 28, 0, 1);
		send_date(2024, 2, 28, 0, 1);
		send_date(2023, 2, 28, 0, 1);
		send_date(2100, 3, 1, 0, 365);
		// year overflow saturates
		send_date(YEAR_MAX, 12, 31, 0, 1);
		send_date(YEAR_MAX, 1, 1, 4095, 65535);
		send_date(YEAR_MAX, 12, 1, 0, 30);
		// largest offsets
		send_date(1, 1, 1, 4095, 65535);
		send_date(9999, 12, 31, 4095, 65535);
		// short months and week counts
		send_date(2024, 4, 30, 0, 1);
		send_date(2024, 6, 15, 1, 0);
		send_date(2023, 12, 31, 52, 0);
		// alternating bit patterns
		send_date(10922, 5, 21, 2730, 43690);
		send_date(5461, 10, 10, 1365, 21845);

		// hold off until the directed dates have all come back
		wait_for_dates();

		for (i = 0; i < RANDOM_DATES; i++) begin
			if (i == CALM_FROM) begin
				sender_idles = 1'b0;
				sink_stalls = 1'b0;
			end
			send_random_date();
		end

		wait_for_dates();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (ledger.errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

FILE: filelist.f
src/cdad_pkg.sv
src/cdad_front.sv
src/cdad_queue.sv
src/cdad_back.sv
src/calendar_date_add_days.sv
tb/calendar_date_add_days_tb.sv
